[rtl/sst_pkg.sv]
package sst_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int FIELD_W         = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_SPARE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_PRESENT = 2'd1,
        STAT_ABSENT  = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [VALUE_W-1:0]  value;
    } op_item_t;

    typedef struct packed {
        status_t                status;
        logic                   found;
        logic [FIELD_W-1:0]     position;
        logic [FIELD_W-1:0]     count;
    } result_item_t;

endpackage

[rtl/sst_mem.sv]
module sst_mem #(
    parameter int DEPTH = sst_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [sst_pkg::VALUE_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [sst_pkg::VALUE_W-1:0] rdata
);
    import sst_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/sorted_set_table_unit.sv]
// Sorted set of distinct signed values held in a single-port-read, single-port-write RAM.
// A search is a binary search, each step waiting on the RAM read at the midpoint, then
// a verify read at the lower bound, skipped when the value lies above every entry. Inserts
// and removes also move each entry past that position one place, by a read then a write.
// One item is worked on at a time; busy is high from acceptance until the strobe cycle.
// Reset clears the entry count and the control state; the RAM contents are not cleared.
module sorted_set_table_unit #(
    parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sst_pkg::op_item_t     op,
    output logic                  done,
    output sst_pkg::result_item_t result
);
    import sst_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PROBE  = 9'b000000010,
        S_STEP   = 9'b000000100,
        S_VERIFY = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_INS_RD = 9'b000100000,
        S_INS_WR = 9'b001000000,
        S_REM_RD = 9'b010000000,
        S_REM_WR = 9'b100000000
    } state_t;

    state_t         state_reg, state_next;
    op_item_t       op_reg, op_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           found_reg, found_next;
    logic           done_reg, done_next;
    result_item_t   result_reg, result_next;

    logic [CW-1:0]       mid;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [VALUE_W-1:0]  wdata;
    logic [AW-1:0]       raddr;
    logic [VALUE_W-1:0]  rdata;
    logic                finish;
    status_t             fin_status;

    sst_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = idx_reg[AW-1:0];
        wdata       = rdata;
        raddr       = mid[AW-1:0];
        finish      = 1'b0;
        fin_status  = STAT_DONE;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    raddr      = mid[AW-1:0];
                    state_next = S_STEP;
                end
                else if (lo_reg < count_reg)
                begin
                    raddr      = lo_reg[AW-1:0];
                    state_next = S_VERIFY;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_STEP:
            begin
                if ($signed(rdata) < op_reg.value)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_PROBE;
            end
            S_VERIFY:
            begin
                found_next = (rdata == op_reg.value);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                case (op_reg.kind)
                    KIND_INSERT:
                    begin
                        if (found_reg)
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_PRESENT;
                        end
                        else if (count_reg >= DEPTH_C)
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_FULL;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            idx_next   = lo_reg;
                            state_next = S_REM_RD;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_ABSENT;
                        end
                    end
                    default:
                    begin
                        // The spare kind code behaves as a search.
                        finish     = 1'b1;
                        fin_status = found_reg ? STAT_DONE : STAT_ABSENT;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (idx_reg > lo_reg)
                begin
                    raddr      = idx_reg[AW-1:0] - AW'(1);
                    state_next = S_INS_WR;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = lo_reg[AW-1:0];
                    wdata      = op_reg.value;
                    count_next = count_reg + CW'(1);
                    finish     = 1'b1;
                    fin_status = STAT_DONE;
                end
            end
            S_INS_WR:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata;
                idx_next   = idx_reg - CW'(1);
                state_next = S_INS_RD;
            end
            S_REM_RD:
            begin
                if ((idx_reg + CW'(1)) < count_reg)
                begin
                    raddr      = idx_reg[AW-1:0] + AW'(1);
                    state_next = S_REM_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    finish     = 1'b1;
                    fin_status = STAT_DONE;
                end
            end
            S_REM_WR:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata;
                idx_next   = idx_reg + CW'(1);
                state_next = S_REM_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next            = 1'b1;
            result_next.status   = fin_status;
            result_next.found    = found_reg;
            result_next.position = FIELD_W'(lo_reg);
            result_next.count    = FIELD_W'(count_next);
            state_next           = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
